>>> hw/rtl/mecanum_odometry_integrator_macros.svh
// ============================================================================
// Mecanum odometry integrator assertion macros
// Shared property wrappers clocked on clk and disabled while rst_n is low.
// ============================================================================
`ifndef MECANUM_ODOMETRY_INTEGRATOR_MACROS_SVH
`define MECANUM_ODOMETRY_INTEGRATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MOI_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mecanum odometry check failed");

// Consequent must hold in the cycle after the antecedent.
`define MOI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mecanum odometry check failed");

`endif

>>> hw/rtl/moi_pkg.sv
// ============================================================================
// Mecanum odometry integrator package
// Transaction types, sequencer codes and arithmetic constants.
// ============================================================================
package moi_pkg;

    localparam int SINE_TABLE_BITS = 12;

    // Bit-serial multiplier: a is loaded whole, b is consumed one bit a cycle.
    localparam int MUL_A_W = 48;
    localparam int MUL_B_W = 34;
    localparam int CNT_W   = $clog2(MUL_B_W);

    localparam logic [29:0] SIN_B = 30'd688904866;
    localparam logic [30:0] SIN_A = 31'd1686629713;
    localparam logic [26:0] SIN_C = 27'd76016977;

    localparam logic [46:0] STEP_MAX = {47{1'b1}};
    localparam logic [47:0] POS_MAX  = {1'b0, {47{1'b1}}};
    localparam logic [47:0] POS_MIN  = {1'b1, {47{1'b0}}};

    localparam logic [SINE_TABLE_BITS-1:0] SINE_QUARTER =
        SINE_TABLE_BITS'(1) << (SINE_TABLE_BITS - 2);

    typedef struct packed {
        logic        cmd;
        logic        reads_ok;
        logic [31:0] count_0;
        logic [31:0] count_1;
        logic [31:0] count_2;
        logic [31:0] count_3;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [31:0] heading;
        logic               updated;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_LOAD,
        ST_RUN,
        ST_STORE,
        ST_ACC,
        ST_OUT
    } state_t;

    // Products in the order the sequencer forms them.
    typedef enum logic [3:0] {
        OP_FX,
        OP_FY,
        OP_ANG,
        OP_SX2,
        OP_ST1,
        OP_ST2,
        OP_ST3,
        OP_CX2,
        OP_CT1,
        OP_CT2,
        OP_CT3,
        OP_RXC,
        OP_RYS,
        OP_RXS,
        OP_RYC
    } op_t;

endpackage

>>> hw/rtl/mecanum_odometry_integrator.sv
// An encoder sample is summed, multiplied out, accumulated and then output;
// a reset command or a failed read goes straight to the output state.
// One transaction at a time: the next waits until the last result is registered.
// A single shared bit-serial multiplier forms each of the fifteen products of a
// sample in turn (load, 34 shift-and-add steps, store).
// Reset clears the counts, pose and scales.
// ============================================================================
// Mecanum odometry integrator
// Integrates mecanum wheel encoder counts into an x, y and heading pose.
// ============================================================================
`include "mecanum_odometry_integrator_macros.svh"

module mecanum_odometry_integrator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  moi_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output moi_pkg::out_item_t out_data
);

    localparam int TB = moi_pkg::SINE_TABLE_BITS;

    moi_pkg::state_t state_reg, state_next;
    moi_pkg::op_t    op_reg, op_next;
    logic [moi_pkg::CNT_W-1:0] bit_cnt_reg, bit_cnt_next;

    logic [31:0] lin_scale_reg, lin_scale_next;
    logic [31:0] turn_scale_reg, turn_scale_next;
    logic [31:0] last_count_reg [4];
    logic [31:0] last_count_next [4];
    logic [47:0] acc_x_reg, acc_x_next;
    logic [47:0] acc_y_reg, acc_y_next;
    logic [31:0] acc_heading_reg, acc_heading_next;
    logic        out_valid_reg, out_valid_next;

    moi_pkg::out_item_t out_data_reg, out_data_next;
    logic        upd_reg, upd_next;
    logic [31:0] delta_reg [4];
    logic [31:0] delta_next [4];
    logic [33:0] sx_reg, sx_next;
    logic [33:0] sy_reg, sy_next;
    logic [33:0] sr_reg, sr_next;
    logic [46:0] fx_mag_reg, fx_mag_next;
    logic        fx_neg_reg, fx_neg_next;
    logic [46:0] fy_mag_reg, fy_mag_next;
    logic        fy_neg_reg, fy_neg_next;
    logic [31:0] dang_reg, dang_next;
    logic [30:0] x_reg, x_next;
    logic [1:0]  quad_reg, quad_next;
    logic [30:0] x2_reg, x2_next;
    logic [30:0] t_reg, t_next;
    logic [30:0] sin_mag_reg, sin_mag_next;
    logic        sin_neg_reg, sin_neg_next;
    logic [30:0] cos_mag_reg, cos_mag_next;
    logic        cos_neg_reg, cos_neg_next;
    logic [49:0] rot_xc_reg, rot_xc_next;
    logic [49:0] rot_ys_reg, rot_ys_next;
    logic [49:0] rot_xs_reg, rot_xs_next;
    logic [49:0] rot_yc_reg, rot_yc_next;
    logic [moi_pkg::MUL_A_W-1:0] mul_a_reg, mul_a_next;
    logic [moi_pkg::MUL_A_W-1:0] mul_hi_reg, mul_hi_next;
    logic [moi_pkg::MUL_B_W-1:0] mul_lo_reg, mul_lo_next;

    // Datapath helpers
    logic [moi_pkg::MUL_A_W:0]                 mul_sum;
    logic [moi_pkg::MUL_A_W+moi_pkg::MUL_B_W-1:0] prod;
    logic [33:0]   sx_abs, sy_abs, sr_abs;
    logic [31:0]   half_ang, mid_ang;
    logic [TB-1:0] base_idx, trig_idx;
    logic [1:0]    trig_quad;
    logic [30:0]   trig_frac, trig_x;
    logic [46:0]   lin_sat;
    logic [47:0]   ang_low, ang_signed;
    logic [47:0]   rot_mag;
    logic [49:0]   rot_pos, rot_negv;
    logic [51:0]   sum_x, sum_y;
    logic [47:0]   new_x, new_y;

    assign pready    = 1'b1;
    assign prdata    = paddr[2] ? turn_scale_reg : lin_scale_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // One shift-and-add step: add a when the low multiplier bit is set, then shift right.
    assign mul_sum = {1'b0, mul_hi_reg} + (mul_lo_reg[0] ? {1'b0, mul_a_reg} : '0);
    assign prod    = {mul_hi_reg, mul_lo_reg};

    assign sx_abs = sx_reg[33] ? (~sx_reg + 34'd1) : sx_reg;
    assign sy_abs = sy_reg[33] ? (~sy_reg + 34'd1) : sy_reg;
    assign sr_abs = sr_reg[33] ? (~sr_reg + 34'd1) : sr_reg;

    // Midpoint heading and the quarter-wave argument of the sine or cosine.
    assign half_ang  = {dang_reg[31], dang_reg[31:1]};
    assign mid_ang   = acc_heading_reg + half_ang;
    assign base_idx  = mid_ang[31 -: TB];
    assign trig_idx  = (op_reg == moi_pkg::OP_CX2) ? base_idx + moi_pkg::SINE_QUARTER
                                                    : base_idx;
    assign trig_quad = trig_idx[TB-1 -: 2];
    assign trig_frac = {1'b0, trig_idx[TB-3:0], {(32-TB){1'b0}}};
    assign trig_x    = trig_quad[0] ? (31'h4000_0000 - trig_frac) : trig_frac;

    assign lin_sat    = (|prod[81:57]) ? moi_pkg::STEP_MAX : prod[56:10];
    assign ang_low    = prod[47:0];
    assign ang_signed = sr_reg[33] ? (~ang_low + 48'd1) : ang_low;
    assign rot_mag    = prod[77:30];
    assign rot_pos    = {2'b00, rot_mag};
    assign rot_negv   = ~rot_pos + 50'd1;

    assign sum_x = {{4{acc_x_reg[47]}}, acc_x_reg} + {{2{rot_xc_reg[49]}}, rot_xc_reg}
                 - {{2{rot_ys_reg[49]}}, rot_ys_reg};
    assign sum_y = {{4{acc_y_reg[47]}}, acc_y_reg} + {{2{rot_xs_reg[49]}}, rot_xs_reg}
                 + {{2{rot_yc_reg[49]}}, rot_yc_reg};
    assign new_x = (sum_x[51:47] == 5'b00000 || sum_x[51:47] == 5'b11111) ? sum_x[47:0]
                 : (sum_x[51] ? moi_pkg::POS_MIN : moi_pkg::POS_MAX);
    assign new_y = (sum_y[51:47] == 5'b00000 || sum_y[51:47] == 5'b11111) ? sum_y[47:0]
                 : (sum_y[51] ? moi_pkg::POS_MIN : moi_pkg::POS_MAX);

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        bit_cnt_next     = bit_cnt_reg;
        lin_scale_next   = lin_scale_reg;
        turn_scale_next  = turn_scale_reg;
        last_count_next  = last_count_reg;
        acc_x_next       = acc_x_reg;
        acc_y_next       = acc_y_reg;
        acc_heading_next = acc_heading_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_data_next    = out_data_reg;
        upd_next         = upd_reg;
        delta_next       = delta_reg;
        sx_next          = sx_reg;
        sy_next          = sy_reg;
        sr_next          = sr_reg;
        fx_mag_next      = fx_mag_reg;
        fx_neg_next      = fx_neg_reg;
        fy_mag_next      = fy_mag_reg;
        fy_neg_next      = fy_neg_reg;
        dang_next        = dang_reg;
        x_next           = x_reg;
        quad_next        = quad_reg;
        x2_next          = x2_reg;
        t_next           = t_reg;
        sin_mag_next     = sin_mag_reg;
        sin_neg_next     = sin_neg_reg;
        cos_mag_next     = cos_mag_reg;
        cos_neg_next     = cos_neg_reg;
        rot_xc_next      = rot_xc_reg;
        rot_ys_next      = rot_ys_reg;
        rot_xs_next      = rot_xs_reg;
        rot_yc_next      = rot_yc_reg;
        mul_a_next       = mul_a_reg;
        mul_hi_next      = mul_hi_reg;
        mul_lo_next      = mul_lo_reg;
        in_ready         = 1'b0;

        if (psel && penable && pwrite) begin
            if (paddr[2]) begin
                turn_scale_next = pwdata;
            end else begin
                lin_scale_next = pwdata;
            end
        end

        case (state_reg)
            moi_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_data.cmd) begin
                        for (int i = 0; i < 4; i++) begin
                            last_count_next[i] = '0;
                        end
                        acc_x_next       = '0;
                        acc_y_next       = '0;
                        acc_heading_next = '0;
                        upd_next         = 1'b1;
                        state_next       = moi_pkg::ST_OUT;
                    end else if (!in_data.reads_ok) begin
                        upd_next   = 1'b0;
                        state_next = moi_pkg::ST_OUT;
                    end else begin
                        delta_next[0] = in_data.count_0 - last_count_reg[0];
                        delta_next[1] = in_data.count_1 - last_count_reg[1];
                        delta_next[2] = in_data.count_2 - last_count_reg[2];
                        delta_next[3] = in_data.count_3 - last_count_reg[3];
                        last_count_next[0] = in_data.count_0;
                        last_count_next[1] = in_data.count_1;
                        last_count_next[2] = in_data.count_2;
                        last_count_next[3] = in_data.count_3;
                        state_next = moi_pkg::ST_SUM;
                    end
                end
            end

            moi_pkg::ST_SUM:
            begin
                sx_next = {{2{delta_reg[1][31]}}, delta_reg[1]}
                        + {{2{delta_reg[2][31]}}, delta_reg[2]}
                        - {{2{delta_reg[0][31]}}, delta_reg[0]}
                        - {{2{delta_reg[3][31]}}, delta_reg[3]};
                sy_next = {{2{delta_reg[0][31]}}, delta_reg[0]}
                        + {{2{delta_reg[1][31]}}, delta_reg[1]}
                        + {{2{delta_reg[2][31]}}, delta_reg[2]}
                        + {{2{delta_reg[3][31]}}, delta_reg[3]};
                sr_next = {{2{delta_reg[1][31]}}, delta_reg[1]}
                        + {{2{delta_reg[3][31]}}, delta_reg[3]}
                        - {{2{delta_reg[0][31]}}, delta_reg[0]}
                        - {{2{delta_reg[2][31]}}, delta_reg[2]};
                op_next    = moi_pkg::OP_FX;
                state_next = moi_pkg::ST_LOAD;
            end

            moi_pkg::ST_LOAD:
            begin
                mul_hi_next  = '0;
                bit_cnt_next = '0;
                case (op_reg)
                    moi_pkg::OP_FX:
                    begin
                        mul_a_next  = {16'd0, lin_scale_reg};
                        mul_lo_next = sx_abs;
                    end
                    moi_pkg::OP_FY:
                    begin
                        mul_a_next  = {16'd0, lin_scale_reg};
                        mul_lo_next = sy_abs;
                    end
                    moi_pkg::OP_ANG:
                    begin
                        mul_a_next  = {16'd0, turn_scale_reg};
                        mul_lo_next = sr_abs;
                    end
                    moi_pkg::OP_SX2, moi_pkg::OP_CX2:
                    begin
                        mul_a_next  = {17'd0, trig_x};
                        mul_lo_next = {3'd0, trig_x};
                        x_next      = trig_x;
                        quad_next   = trig_quad;
                    end
                    moi_pkg::OP_ST1, moi_pkg::OP_CT1:
                    begin
                        mul_a_next  = {21'd0, moi_pkg::SIN_C};
                        mul_lo_next = {3'd0, x2_reg};
                    end
                    moi_pkg::OP_ST2, moi_pkg::OP_CT2:
                    begin
                        mul_a_next  = {17'd0, t_reg};
                        mul_lo_next = {3'd0, x2_reg};
                    end
                    moi_pkg::OP_ST3, moi_pkg::OP_CT3:
                    begin
                        mul_a_next  = {17'd0, t_reg};
                        mul_lo_next = {3'd0, x_reg};
                    end
                    moi_pkg::OP_RXC:
                    begin
                        mul_a_next  = {1'b0, fx_mag_reg};
                        mul_lo_next = {3'd0, cos_mag_reg};
                    end
                    moi_pkg::OP_RYS:
                    begin
                        mul_a_next  = {1'b0, fy_mag_reg};
                        mul_lo_next = {3'd0, sin_mag_reg};
                    end
                    moi_pkg::OP_RXS:
                    begin
                        mul_a_next  = {1'b0, fx_mag_reg};
                        mul_lo_next = {3'd0, sin_mag_reg};
                    end
                    default:
                    begin
                        mul_a_next  = {1'b0, fy_mag_reg};
                        mul_lo_next = {3'd0, cos_mag_reg};
                    end
                endcase
                state_next = moi_pkg::ST_RUN;
            end

            moi_pkg::ST_RUN:
            begin
                mul_hi_next  = mul_sum[moi_pkg::MUL_A_W:1];
                mul_lo_next  = {mul_sum[0], mul_lo_reg[moi_pkg::MUL_B_W-1:1]};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == moi_pkg::CNT_W'(moi_pkg::MUL_B_W - 1)) begin
                    state_next = moi_pkg::ST_STORE;
                end
            end

            moi_pkg::ST_STORE:
            begin
                case (op_reg)
                    moi_pkg::OP_FX:
                    begin
                        fx_mag_next = lin_sat;
                        fx_neg_next = sx_reg[33];
                    end
                    moi_pkg::OP_FY:
                    begin
                        fy_mag_next = lin_sat;
                        fy_neg_next = sy_reg[33];
                    end
                    moi_pkg::OP_ANG:
                    begin
                        dang_next = ang_signed[47:16];
                    end
                    moi_pkg::OP_SX2, moi_pkg::OP_CX2:
                    begin
                        x2_next = prod[60:30];
                    end
                    moi_pkg::OP_ST1, moi_pkg::OP_CT1:
                    begin
                        t_next = {1'b0, moi_pkg::SIN_B} - prod[60:30];
                    end
                    moi_pkg::OP_ST2, moi_pkg::OP_CT2:
                    begin
                        t_next = moi_pkg::SIN_A - prod[60:30];
                    end
                    moi_pkg::OP_ST3:
                    begin
                        sin_mag_next = prod[60:30];
                        sin_neg_next = quad_reg[1];
                    end
                    moi_pkg::OP_CT3:
                    begin
                        cos_mag_next = prod[60:30];
                        cos_neg_next = quad_reg[1];
                    end
                    moi_pkg::OP_RXC:
                    begin
                        rot_xc_next = (fx_neg_reg ^ cos_neg_reg) ? rot_negv : rot_pos;
                    end
                    moi_pkg::OP_RYS:
                    begin
                        rot_ys_next = (fy_neg_reg ^ sin_neg_reg) ? rot_negv : rot_pos;
                    end
                    moi_pkg::OP_RXS:
                    begin
                        rot_xs_next = (fx_neg_reg ^ sin_neg_reg) ? rot_negv : rot_pos;
                    end
                    default:
                    begin
                        rot_yc_next = (fy_neg_reg ^ cos_neg_reg) ? rot_negv : rot_pos;
                    end
                endcase
                if (op_reg == moi_pkg::OP_RYC) begin
                    state_next = moi_pkg::ST_ACC;
                end else begin
                    op_next    = moi_pkg::op_t'(op_reg + 4'd1);
                    state_next = moi_pkg::ST_LOAD;
                end
            end

            moi_pkg::ST_ACC:
            begin
                acc_x_next       = new_x;
                acc_y_next       = new_y;
                acc_heading_next = acc_heading_reg + dang_reg;
                upd_next         = 1'b1;
                state_next       = moi_pkg::ST_OUT;
            end

            moi_pkg::ST_OUT:
            begin
                // Hold here until the output register is free.
                if (!out_valid_reg || out_ready) begin
                    out_valid_next        = 1'b1;
                    out_data_next.pos_x   = acc_x_reg[47:16];
                    out_data_next.pos_y   = acc_y_reg[47:16];
                    out_data_next.heading = acc_heading_reg;
                    out_data_next.updated = upd_reg;
                    state_next            = moi_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = moi_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg       <= moi_pkg::ST_IDLE;
            op_reg          <= moi_pkg::OP_FX;
            bit_cnt_reg     <= '0;
            lin_scale_reg   <= '0;
            turn_scale_reg  <= '0;
            for (int i = 0; i < 4; i++) begin
                last_count_reg[i] <= '0;
            end
            acc_x_reg       <= '0;
            acc_y_reg       <= '0;
            acc_heading_reg <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            bit_cnt_reg     <= bit_cnt_next;
            lin_scale_reg   <= lin_scale_next;
            turn_scale_reg  <= turn_scale_next;
            last_count_reg  <= last_count_next;
            acc_x_reg       <= acc_x_next;
            acc_y_reg       <= acc_y_next;
            acc_heading_reg <= acc_heading_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        upd_reg      <= upd_next;
        delta_reg    <= delta_next;
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        sr_reg       <= sr_next;
        fx_mag_reg   <= fx_mag_next;
        fx_neg_reg   <= fx_neg_next;
        fy_mag_reg   <= fy_mag_next;
        fy_neg_reg   <= fy_neg_next;
        dang_reg     <= dang_next;
        x_reg        <= x_next;
        quad_reg     <= quad_next;
        x2_reg       <= x2_next;
        t_reg        <= t_next;
        sin_mag_reg  <= sin_mag_next;
        sin_neg_reg  <= sin_neg_next;
        cos_mag_reg  <= cos_mag_next;
        cos_neg_reg  <= cos_neg_next;
        rot_xc_reg   <= rot_xc_next;
        rot_ys_reg   <= rot_ys_next;
        rot_xs_reg   <= rot_xs_next;
        rot_yc_reg   <= rot_yc_next;
        mul_a_reg    <= mul_a_next;
        mul_hi_reg   <= mul_hi_next;
        mul_lo_reg   <= mul_lo_next;
    end

    // A new transaction is never taken in the cycle after one was accepted.
    `MOI_ASSERT_NEXT(a_no_double_accept, in_valid && in_ready, !in_ready)
    // A finished result that is not yet taken keeps the sequencer parked.
    `MOI_ASSERT_NEXT(a_out_park, state_reg == moi_pkg::ST_OUT && out_valid_reg && !out_ready,
                     state_reg == moi_pkg::ST_OUT)
    // The reset command has zeroed the pose by the cycle after its acceptance.
    `MOI_ASSERT_NEXT(a_cmd_clear, in_valid && in_ready && in_data.cmd,
                     acc_x_reg == '0 && acc_y_reg == '0 && acc_heading_reg == '0)
    // The bit counter stays inside the multiplier operand while it runs.
    `MOI_ASSERT_SAME(a_cnt_range, state_reg == moi_pkg::ST_RUN,
                     bit_cnt_reg < moi_pkg::CNT_W'(moi_pkg::MUL_B_W))

endmodule

>>> dv/mecanum_odometry_integrator_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// Mecanum odometry pose checker
// Watches both channels, predicts each pose result from the accepted encoder
// transaction and the current scales, and compares each result as a whole.
// ============================================================================
module mecanum_odometry_integrator_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  moi_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  moi_pkg::out_item_t out_data,
    input  logic [31:0]        lin_scale,
    input  logic [31:0]        turn_scale,
    output int                 fail_count,
    output int                 pending
);

    localparam logic signed [63:0] POSE_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] POSE_LO = -64'sh0000_8000_0000_0000;

    logic [31:0]        wheel_last [4];
    logic signed [63:0] pose_x;
    logic signed [63:0] pose_y;
    logic [31:0]        pose_heading;
    moi_pkg::out_item_t pose_queue [$];

    assign pending = pose_queue.size();

    function automatic logic signed [63:0] quarter_sine(logic [31:0] idx);
        logic [31:0] p;
        logic [63:0] x, x2, t;
        p = (idx & ((32'd1 << moi_pkg::SINE_TABLE_BITS) - 1))
            << (32 - moi_pkg::SINE_TABLE_BITS);
        x = {34'd0, p[29:0]};
        if (p[30])
            x = 64'h4000_0000 - x;
        x2 = (x * x) >> 30;
        t = (64'(moi_pkg::SIN_C) * x2) >> 30;
        t = 64'(moi_pkg::SIN_B) - t;
        t = (t * x2) >> 30;
        t = 64'(moi_pkg::SIN_A) - t;
        t = (t * x) >> 30;
        return p[31] ? -$signed(t) : $signed(t);
    endfunction

    function automatic logic signed [63:0] body_step(logic signed [63:0] s);
        logic [63:0] m, r;
        m = s < 0 ? -s : s;
        r = ((m * lin_scale[31:16]) << 6) + ((m * lin_scale[15:0]) >> 10);
        if (r > 64'h7FFF_FFFF_FFFF)
            r = 64'h7FFF_FFFF_FFFF;
        return s < 0 ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [63:0] rotate_q30(logic signed [63:0] v,
                                                      logic signed [63:0] t);
        logic [63:0] mv, mt, a, b, r;
        mv = v < 0 ? -v : v;
        mt = t < 0 ? -t : t;
        a = (mv >> 24) * mt;
        b = (mv & 64'hFF_FFFF) * mt;
        r = (a >> 6) + ((((a & 64'd63) << 24) + b) >> 30);
        return ((v < 0) != (t < 0)) ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [63:0] clamp_pose(logic signed [63:0] v);
        if (v > POSE_HI)
            return POSE_HI;
        if (v < POSE_LO)
            return POSE_LO;
        return v;
    endfunction

    task automatic integrate_sample(input moi_pkg::in_item_t it);
        logic signed [63:0] d [4];
        logic signed [63:0] sx, sy, sr, fx, fy, sn, cs;
        logic [31:0] cnt [4];
        logic [31:0] dang, half, mid, idx;
        logic [63:0] prod;
        moi_pkg::out_item_t res;
        cnt[0] = it.count_0;
        cnt[1] = it.count_1;
        cnt[2] = it.count_2;
        cnt[3] = it.count_3;
        res.updated = 1'b0;
        if (it.cmd) begin
            foreach (wheel_last[i])
                wheel_last[i] = '0;
            pose_x = 0;
            pose_y = 0;
            pose_heading = '0;
            res.updated = 1'b1;
        end else if (it.reads_ok) begin
            for (int i = 0; i < 4; i++) begin
                d[i] = 64'($signed(cnt[i] - wheel_last[i]));
                wheel_last[i] = cnt[i];
            end
            sx = -d[0] + d[1] + d[2] - d[3];
            sy = d[0] + d[1] + d[2] + d[3];
            sr = -d[0] + d[1] - d[2] + d[3];
            fx = body_step(sx);
            fy = body_step(sy);
            prod = $unsigned(sr) * 64'(turn_scale);
            dang = prod[47:16];
            half = {dang[31], dang[31:1]};
            mid = pose_heading + half;
            idx = mid >> (32 - moi_pkg::SINE_TABLE_BITS);
            sn = quarter_sine(idx);
            cs = quarter_sine(idx + (32'd1 << (moi_pkg::SINE_TABLE_BITS - 2)));
            pose_x = clamp_pose(pose_x + (rotate_q30(fx, cs) - rotate_q30(fy, sn)));
            pose_y = clamp_pose(pose_y + (rotate_q30(fx, sn) + rotate_q30(fy, cs)));
            pose_heading = pose_heading + dang;
            res.updated = 1'b1;
        end
        res.pos_x = pose_x[47:16];
        res.pos_y = pose_y[47:16];
        res.heading = pose_heading;
        pose_queue.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n) begin
        moi_pkg::out_item_t want;
        if (!rst_n) begin
            foreach (wheel_last[i])
                wheel_last[i] = '0;
            pose_x = 0;
            pose_y = 0;
            pose_heading = '0;
            fail_count <= 0;
            pose_queue.delete();
        end else begin
            if (out_valid && out_ready) begin
                if (pose_queue.size() == 0) begin
                    $display("%0t: unexpected pose transaction %p", $time, out_data);
                    fail_count <= fail_count + 1;
                end else begin
                    want = pose_queue.pop_front();
                    if (want !== out_data) begin
                        $display("%0t: pose mismatch expected %p actual %p",
                                 $time, want, out_data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // Blocking updates keep the pose in step across back-to-back transactions.
            if (in_valid && in_ready)
                integrate_sample(in_data);
        end
    end

endmodule

>>> dv/mecanum_odometry_integrator_test.sv
`timescale 1ns / 1ps
// ============================================================================
// Mecanum odometry integrator testbench
// Drives encoder transactions and scale writes with random idling; the
// checker predicts every pose result and counts mismatches.
// ============================================================================
module mecanum_odometry_integrator_test;

    localparam int REG_LIN  = 0;
    localparam int REG_TURN = 1;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    moi_pkg::in_item_t  in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    moi_pkg::out_item_t out_data;
    logic [31:0]        lin_scale = '0;
    logic [31:0]        turn_scale = '0;
    int                 fail_count;
    int                 pending;
    bit                 calm = 1'b0;
    logic [31:0]        wheel [4];

    always #4 clk = ~clk;

    mecanum_odometry_integrator i_dut (.*);

    mecanum_odometry_integrator_checker i_checker (.*);

    // The receiver stalls at random except during the calm stretch.
    always @(negedge clk)
        out_ready <= calm || ($urandom_range(99) >= 13);

    task automatic write_scale(input int index, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'(4 * index);
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (index == REG_LIN)
            lin_scale = value;
        else
            turn_scale = value;
    endtask

    // Valid drops at one falling edge and rises no earlier than the next one.
    task automatic send(input moi_pkg::in_item_t it);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 13)
            @(negedge clk);
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic send_counts(input logic cmd, input logic ok);
        moi_pkg::in_item_t it;
        it.cmd = cmd;
        it.reads_ok = ok;
        it.count_0 = wheel[0];
        it.count_1 = wheel[1];
        it.count_2 = wheel[2];
        it.count_3 = wheel[3];
        send(it);
        if (cmd)
            foreach (wheel[i])
                wheel[i] = '0;
    endtask

    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // Moves each wheel by a small signed amount, occasionally a huge one.
    task automatic advance_wheels();
        for (int i = 0; i < 4; i++) begin
            if ($urandom_range(19) == 0)
                wheel[i] = $urandom();
            else
                wheel[i] = wheel[i] + 32'($signed($urandom_range(4000)) - 2000);
        end
    endtask

    task automatic random_phase(input int n);
        for (int k = 0; k < n; k++) begin
            advance_wheels();
            case ($urandom_range(19))
                0: send_counts(1'b1, 1'(($urandom())));
                1, 2: send_counts(1'b0, 1'b0);
                default: send_counts(1'b0, 1'b1);
            endcase
        end
    endtask

    initial begin
        foreach (wheel[i])
            wheel[i] = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: zero scales, then extremes of counts and scales.
        send_counts(1'b0, 1'b1);
        drain();
        write_scale(REG_LIN, 32'hFFFF_FFFF);
        write_scale(REG_TURN, 32'hFFFF_FFFF);
        wheel = '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001};
        send_counts(1'b0, 1'b1);
        wheel = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        send_counts(1'b0, 1'b1);
        wheel = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF};
        send_counts(1'b0, 1'b0);
        send_counts(1'b0, 1'b1);
        // Repeated full-scale forward motion drives the position into saturation.
        for (int k = 1; k <= 6; k++) begin
            wheel = '{32'(k) * 32'h7FFF_0000, 32'(k) * 32'h7FFF_0000,
                      32'(k) * 32'h7FFF_0000, 32'(k) * 32'h7FFF_0000};
            send_counts(1'b0, 1'b1);
        end
        send_counts(1'b1, 1'b0);
        send_counts(1'b1, 1'b1);
        // Pure rotation with a heading change just short of a full turn exercises the heading wrap.
        wheel = '{32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000};
        send_counts(1'b0, 1'b1);
        send_counts(1'b0, 1'b1);
        drain();

        write_scale(REG_LIN, 32'h0001_0000);
        write_scale(REG_TURN, 32'h0040_0000);
        random_phase(600);
        drain();

        write_scale(REG_LIN, $urandom());
        write_scale(REG_TURN, $urandom_range(32'h0100_0000));
        calm = 1'b1;
        random_phase(300);
        calm = 1'b0;
        drain();

        write_scale(REG_LIN, 32'h0);
        write_scale(REG_TURN, 32'hFFFF_FFFF);
        random_phase(200);
        drain();

        write_scale(REG_LIN, $urandom());
        write_scale(REG_TURN, $urandom());
        random_phase(780);
        drain();

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Timeout sized for about 1900 transactions plus stalls, with a wide margin.
    initial begin
        #40_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
